FILE: rtl/core/prct_pkg.sv
`default_nettype none

package prct_pkg;

	localparam int MAX_CLIENTS    = 16;
	localparam int CLIENT_ID_BITS = 32;

	localparam int TALLY_W = 32;
	localparam int OP_W    = 2;
	localparam int IN_ID_W = 32;
	localparam int ID_W    = (CLIENT_ID_BITS < IN_ID_W) ? CLIENT_ID_BITS : IN_ID_W;
	localparam int IDX_W   = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;
	localparam int CNT_W   = $clog2(MAX_CLIENTS + 1);
	localparam int RUN_W   = 38;
	localparam int TOTAL_W = 37;
	localparam int USED_W  = 5;
	localparam int ENTRY_W = 2 * TALLY_W;

	localparam logic [OP_W-1:0] OP_INC   = 2'd0;
	localparam logic [OP_W-1:0] OP_DEC   = 2'd1;
	localparam logic [OP_W-1:0] OP_MERGE = 2'd2;

	typedef struct packed {
		logic capture;
		logic lookup;
		logic update;
		logic load_out;
	} ctrl_cmd_t;

	typedef struct packed {
		logic skip;
	} dp_sts_t;

endpackage

`default_nettype wire

FILE: rtl/core/pn_counter_replica_table.sv
// PN-counter replica table: per-client increment and decrement tallies.
// Input channel (in_valid/in_ready) carries one beat per operation: increment,
// decrement or merge of a remote entry for client_key. Output channel
// (out_valid/out_ready) returns one beat per input beat with the running
// total, a table-full status and the number of entries in use.
// A result reaches the output register through these steps, in order, after its
// input beat is accepted: tag match with tally RAM read, read-modify-write, output load.
// An ignored item skips the write and goes straight to the output load.
// The block works on one item at a time, so it takes no new beat until the
// result of the last one has been loaded into the output register.
// A new item is accepted while a finished result still waits in the output
// register; if the receiver keeps stalling, the next result holds in the
// controller and no further beat is accepted until the register frees up.
// Reset clears all entry valid bits, the entry count and the running total;
// tally storage needs no clearing pass. Operation code 3 changes nothing.
`default_nettype none

module pn_counter_replica_table import prct_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [OP_W-1:0]      operation,
	input  wire logic [IN_ID_W-1:0]   client_key,
	input  wire logic [TALLY_W-1:0]   amount,
	input  wire logic [TALLY_W-1:0]   remote_inc,
	input  wire logic [TALLY_W-1:0]   remote_dec,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic signed [TOTAL_W-1:0] total,
	output logic                      status,
	output logic [USED_W-1:0]         entries_used
);

	ctrl_cmd_t cmd;
	dp_sts_t   sts;

	prct_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	prct_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.operation   (operation),
		.client_key  (client_key),
		.amount      (amount),
		.remote_inc  (remote_inc),
		.remote_dec  (remote_dec),
		.total       (total),
		.status      (status),
		.entries_used(entries_used)
	);

	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.capture, cmd.lookup, cmd.update, cmd.load_out}))
		else $error("controller issued more than one command");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("second item accepted while one is in flight");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status) |-> (entries_used == USED_W'(MAX_CLIENTS)))
		else $error("table-full status with free entries");

endmodule

`default_nettype wire

FILE: rtl/core/prct_ram.sv
`default_nettype none

module prct_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  wire logic                                         clk,
	input  wire logic                                         we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                             wdata,
	input  wire logic                                         re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                             rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/prct_datapath.sv
`default_nettype none

module prct_datapath import prct_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire ctrl_cmd_t             cmd,
	output dp_sts_t                    sts,
	input  wire logic [OP_W-1:0]       operation,
	input  wire logic [IN_ID_W-1:0]    client_key,
	input  wire logic [TALLY_W-1:0]    amount,
	input  wire logic [TALLY_W-1:0]    remote_inc,
	input  wire logic [TALLY_W-1:0]    remote_dec,
	output logic signed [TOTAL_W-1:0]  total,
	output logic                       status,
	output logic [USED_W-1:0]          entries_used
);

	logic [OP_W-1:0]    op_q;
	logic [ID_W-1:0]    id_q;
	logic [TALLY_W-1:0] amount_q;
	logic [TALLY_W-1:0] rinc_q;
	logic [TALLY_W-1:0] rdec_q;

	logic [ID_W-1:0]         ids_q [MAX_CLIENTS];
	logic [MAX_CLIENTS-1:0]  valid_q;
	logic [CNT_W-1:0]        used_q;
	logic signed [RUN_W-1:0] run_q;
	logic [IDX_W-1:0]        slot_q;
	logic                    new_q;
	logic                    full_q;

	logic                   op_ok;
	logic [MAX_CLIENTS-1:0] match;
	logic                   hit;
	logic [IDX_W-1:0]       hit_idx;
	logic [IDX_W-1:0]       free_idx;
	logic [IDX_W-1:0]       sel_idx;
	logic                   full;

	logic [ENTRY_W-1:0]      rd_data;
	logic [TALLY_W-1:0]      oi, od, ni, nd;
	logic signed [TALLY_W:0] di, dd;
	logic signed [RUN_W-1:0] run_nx;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q     <= operation;
			id_q     <= client_key[ID_W-1:0];
			amount_q <= amount;
			rinc_q   <= remote_inc;
			rdec_q   <= remote_dec;
		end
		if (cmd.lookup) begin
			slot_q <= sel_idx;
			new_q  <= !hit;
			full_q <= op_ok && full;
		end
		if (cmd.update && new_q) begin
			ids_q[slot_q] <= id_q;
		end
		if (cmd.load_out) begin
			total        <= run_q[TOTAL_W-1:0];
			status       <= full_q;
			entries_used <= USED_W'(used_q);
		end
	end

	always_comb begin
		op_ok    = op_q inside {OP_INC, OP_DEC, OP_MERGE};
		hit_idx  = '0;
		free_idx = '0;
		for (int i = MAX_CLIENTS - 1; i >= 0; i--) begin
			match[i] = valid_q[i] && (ids_q[i] == id_q);
			if (match[i]) begin
				hit_idx = IDX_W'(i);
			end
			if (!valid_q[i]) begin
				free_idx = IDX_W'(i);
			end
		end
		hit      = |match;
		full     = !hit && (&valid_q);
		sel_idx  = hit ? hit_idx : free_idx;
		sts.skip = !op_ok || full;
	end

	prct_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(MAX_CLIENTS)
	) u_tally_ram (
		.clk  (clk),
		.we   (cmd.update),
		.waddr(slot_q),
		.wdata({ni, nd}),
		.re   (cmd.lookup),
		.raddr(sel_idx),
		.rdata(rd_data)
	);

	// A newly allocated entry starts from zero tallies.
	always_comb begin
		oi = new_q ? '0 : rd_data[ENTRY_W-1:TALLY_W];
		od = new_q ? '0 : rd_data[TALLY_W-1:0];
		ni = oi;
		nd = od;
		case (op_q)
			OP_INC: begin
				ni = oi + amount_q;
			end
			OP_DEC: begin
				nd = od + amount_q;
			end
			OP_MERGE: begin
				ni = (rinc_q > oi) ? rinc_q : oi;
				nd = (rdec_q > od) ? rdec_q : od;
			end
			default: begin
				ni = oi;
				nd = od;
			end
		endcase
		di     = $signed({1'b0, ni}) - $signed({1'b0, oi});
		dd     = $signed({1'b0, nd}) - $signed({1'b0, od});
		run_nx = run_q + RUN_W'(di) - RUN_W'(dd);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			used_q  <= '0;
			run_q   <= '0;
		end else if (cmd.update) begin
			run_q <= run_nx;
			if (new_q) begin
				valid_q[slot_q] <= 1'b1;
				used_q          <= used_q + CNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/prct_ctrl.sv
`default_nettype none

module prct_ctrl import prct_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_ready,
	output logic         out_valid,
	input  wire logic    out_ready,
	input  wire dp_sts_t sts,
	output ctrl_cmd_t    cmd
);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_LOOKUP = 4'b0010,
		ST_UPDATE = 4'b0100,
		ST_RESULT = 4'b1000
	} state_t;

	state_t state_q, state_nx;
	logic   out_valid_q;

	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_nx    = ST_LOOKUP;
				end
			end
			ST_LOOKUP: begin
				cmd.lookup = 1'b1;
				state_nx   = sts.skip ? ST_RESULT : ST_UPDATE;
			end
			ST_UPDATE: begin
				cmd.update = 1'b1;
				state_nx   = ST_RESULT;
			end
			ST_RESULT: begin
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_nx     = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire
